>>> rtl/core/lwbpb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwbpb_pkg: shared types and constants
// Widths, operation and result codes and the sequencer state type.
// ----------------------------------------------------------------------------
package lwbpb_pkg;

   localparam int NUM_SLOTS        = 4;
   localparam int FILE_ID_BITS     = 8;
   localparam int PAGE_NUMBER_BITS = 24;
   localparam int SLOT_BITS        = $clog2(NUM_SLOTS);
   localparam int QUEUE_DEPTH      = 2;
   localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_CLOSE = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_ACCESS    = 2'd0,
      KIND_WRITEBACK = 2'd1,
      KIND_CLOSE     = 2'd2,
      KIND_RSVD      = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLOSE,
      ST_MISS_WB,
      ST_RESP
   } state_type;

   // Front-to-back command record.
   typedef struct packed {
      logic                        is_close;
      logic                        is_write;
      logic [FILE_ID_BITS-1:0]     file_id;
      logic [PAGE_NUMBER_BITS-1:0] page_number;
   } cmd_type;

endpackage

>>> rtl/core/lwbpb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwbpb_req_if / lwbpb_rsp_if: request and response channels
// Valid/ready channels carrying one item each.
// ----------------------------------------------------------------------------
interface lwbpb_req_if import lwbpb_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [1:0]                  op;
   logic [FILE_ID_BITS-1:0]     file_id;
   logic [PAGE_NUMBER_BITS-1:0] page_number;
   modport source (output valid, op, file_id, page_number, input ready);
   modport sink   (input valid, op, file_id, page_number, output ready);
endinterface

interface lwbpb_rsp_if import lwbpb_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [1:0]                  result_kind;
   logic                        was_hit;
   logic [SLOT_BITS-1:0]        slot_index;
   logic [FILE_ID_BITS-1:0]     victim_file;
   logic [PAGE_NUMBER_BITS-1:0] victim_page;
   logic                        last_result;
   modport source (output valid, result_kind, was_hit, slot_index, victim_file,
                   victim_page, last_result, input ready);
   modport sink   (input valid, result_kind, was_hit, slot_index, victim_file,
                   victim_page, last_result, output ready);
endinterface

>>> rtl/core/lwbpb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwbpb_front: request intake
// Classify requests, drop unused op codes, push commands into a small queue.
// ----------------------------------------------------------------------------
module lwbpb_front import lwbpb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  logic [1:0] req_op,
   input  logic [FILE_ID_BITS-1:0] req_file_id,
   input  logic [PAGE_NUMBER_BITS-1:0] req_page_number,
   output logic    cmd_valid,
   input  logic    cmd_pop,
   output cmd_type cmd
);
   cmd_type                mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QUEUE_PTR_BITS:0]   cnt_ff, cnt_in;
   logic                      push, keep;
   cmd_type                   new_cmd;

   assign req_ready = (cnt_ff != (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign keep      = (op_type'(req_op) != OP_NONE);
   assign push      = req_valid && req_ready && keep;
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = mem[rd_ff];

   always_comb begin
      new_cmd.is_close    = (op_type'(req_op) == OP_CLOSE);
      new_cmd.is_write    = (op_type'(req_op) == OP_WRITE);
      new_cmd.file_id     = req_file_id;
      new_cmd.page_number = req_page_number;
      wr_in  = push ? QUEUE_PTR_BITS'((32'(wr_ff) + 1) % QUEUE_DEPTH) : wr_ff;
      rd_in  = cmd_pop ? QUEUE_PTR_BITS'((32'(rd_ff) + 1) % QUEUE_DEPTH) : rd_ff;
      cnt_in = cnt_ff + (QUEUE_PTR_BITS+1)'(push) - (QUEUE_PTR_BITS+1)'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem[wr_ff] <= new_cmd;
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH)) else $error("queue overflow");
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid) else $error("pop on empty queue");
   a_drop_none: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !keep) |=> cnt_ff == $past(cnt_in))
      else $error("unused op queued");
`endif
endmodule

>>> rtl/core/lwbpb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwbpb_back: slot tags, dirty bits, recency and response sequencing
// Execute one command at a time and emit its results through an output reg.
// ----------------------------------------------------------------------------
module lwbpb_back import lwbpb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_pop,
   input  cmd_type cmd,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output logic [1:0] rsp_result_kind,
   output logic    rsp_was_hit,
   output logic [SLOT_BITS-1:0] rsp_slot_index,
   output logic [FILE_ID_BITS-1:0] rsp_victim_file,
   output logic [PAGE_NUMBER_BITS-1:0] rsp_victim_page,
   output logic    rsp_last_result
);
   logic [NUM_SLOTS-1:0]        valid_ff, valid_in, dirty_ff, dirty_in;
   logic [FILE_ID_BITS-1:0]     ftag_ff [NUM_SLOTS];
   logic [PAGE_NUMBER_BITS-1:0] ptag_ff [NUM_SLOTS];
   logic [SLOT_BITS-1:0]        rank_ff [NUM_SLOTS];
   logic [SLOT_BITS-1:0]        rank_in [NUM_SLOTS];
   state_type                   state_ff, state_in;
   logic [SLOT_BITS-1:0]        rptr_ff, rptr_in;   // close scan rank
   logic [SLOT_BITS-1:0]        tgt_ff, tgt_in;
   logic                        hit_ff, hit_in;

   logic                        ovalid_ff, ovalid_in;
   logic [1:0]                  okind_ff, okind_in;
   logic                        ohit_ff, ohit_in;
   logic [SLOT_BITS-1:0]        oslot_ff, oslot_in;
   logic [FILE_ID_BITS-1:0]     ofile_ff, ofile_in;
   logic [PAGE_NUMBER_BITS-1:0] opage_ff, opage_in;
   logic                        olast_ff, olast_in;

   logic                        out_free;
   logic [NUM_SLOTS-1:0]        hit_vec, free_vec;
   logic                        any_hit, any_free;
   logic [SLOT_BITS-1:0]        hit_slot, free_slot, lru_slot, miss_slot;
   logic [SLOT_BITS:0]          best_rank;
   logic [SLOT_BITS-1:0]        scan_slot;
   logic                        do_touch, do_fill;
   logic [SLOT_BITS-1:0]        touch_slot;

   assign out_free = !ovalid_ff || rsp_ready;

   // Parallel tag compare and priority pick by rank.
   always_comb begin
      any_hit = 1'b0; any_free = 1'b0;
      hit_slot = '0; free_slot = '0; lru_slot = '0; scan_slot = '0;
      best_rank = (SLOT_BITS+1)'(NUM_SLOTS);
      for (int i = 0; i < NUM_SLOTS; i++) begin
         hit_vec[i]  = valid_ff[i] && ftag_ff[i] == cmd.file_id
                       && ptag_ff[i] == cmd.page_number;
         free_vec[i] = !valid_ff[i];
         if (hit_vec[i]) begin
            any_hit = 1'b1; hit_slot = SLOT_BITS'(i);
         end
         if (rank_ff[i] == SLOT_BITS'(NUM_SLOTS-1)) lru_slot = SLOT_BITS'(i);
         if (rank_ff[i] == rptr_ff) scan_slot = SLOT_BITS'(i);
         if (free_vec[i] && {1'b0, rank_ff[i]} < best_rank) begin
            best_rank = {1'b0, rank_ff[i]};
            free_slot = SLOT_BITS'(i);
            any_free  = 1'b1;
         end
      end
      miss_slot = any_free ? free_slot : lru_slot;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && out_free) begin
               if (cmd.is_close) state_in = ST_CLOSE;
               else if (!any_hit && !any_free && dirty_ff[lru_slot])
                  state_in = ST_MISS_WB;
            end
         end
         ST_CLOSE: begin
            if (out_free && rptr_ff == SLOT_BITS'(NUM_SLOTS-1)) state_in = ST_RESP;
         end
         ST_MISS_WB: if (out_free) state_in = ST_IDLE;
         ST_RESP:    if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff; dirty_in = dirty_ff;
      rptr_in = rptr_ff; tgt_in = tgt_ff; hit_in = hit_ff;
      ovalid_in = ovalid_ff && !rsp_ready;
      okind_in = okind_ff; ohit_in = ohit_ff; oslot_in = oslot_ff;
      ofile_in = ofile_ff; opage_in = opage_ff; olast_in = olast_ff;
      cmd_pop = 1'b0; do_touch = 1'b0; do_fill = 1'b0; touch_slot = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && out_free) begin
               if (cmd.is_close) begin
                  rptr_in = '0;
               end else if (any_hit) begin
                  cmd_pop = 1'b1; do_touch = 1'b1; touch_slot = hit_slot;
                  if (cmd.is_write) dirty_in[hit_slot] = 1'b1;
                  ovalid_in = 1'b1; okind_in = KIND_ACCESS; ohit_in = 1'b1;
                  oslot_in = hit_slot; ofile_in = '0; opage_in = '0;
                  olast_in = 1'b1;
               end else if (!any_free && dirty_ff[lru_slot]) begin
                  tgt_in = lru_slot;
                  ovalid_in = 1'b1; okind_in = KIND_WRITEBACK; ohit_in = 1'b0;
                  oslot_in = lru_slot; ofile_in = ftag_ff[lru_slot];
                  opage_in = ptag_ff[lru_slot]; olast_in = 1'b0;
               end else begin
                  cmd_pop = 1'b1; do_touch = 1'b1; do_fill = 1'b1;
                  touch_slot = miss_slot;
                  valid_in[miss_slot] = 1'b1;
                  dirty_in[miss_slot] = cmd.is_write;
                  ovalid_in = 1'b1; okind_in = KIND_ACCESS; ohit_in = 1'b0;
                  oslot_in = miss_slot; ofile_in = '0; opage_in = '0;
                  olast_in = 1'b1;
               end
            end
         end
         ST_MISS_WB: begin
            if (out_free) begin
               cmd_pop = 1'b1; do_touch = 1'b1; do_fill = 1'b1;
               touch_slot = tgt_ff;
               valid_in[tgt_ff] = 1'b1;
               dirty_in[tgt_ff] = cmd.is_write;
               ovalid_in = 1'b1; okind_in = KIND_ACCESS; ohit_in = 1'b0;
               oslot_in = tgt_ff; ofile_in = '0; opage_in = '0;
               olast_in = 1'b1;
            end
         end
         ST_CLOSE: begin
            // Walk ranks most recent first, one per cycle while the output register is free.
            if (out_free) begin
               rptr_in = rptr_ff + 1'b1;
               if (valid_ff[scan_slot] && ftag_ff[scan_slot] == cmd.file_id) begin
                  if (dirty_ff[scan_slot]) begin
                     ovalid_in = 1'b1; okind_in = KIND_WRITEBACK; ohit_in = 1'b0;
                     oslot_in = scan_slot; ofile_in = ftag_ff[scan_slot];
                     opage_in = ptag_ff[scan_slot]; olast_in = 1'b0;
                  end
                  valid_in[scan_slot] = 1'b0;
                  dirty_in[scan_slot] = 1'b0;
               end
            end
         end
         ST_RESP: begin
            if (out_free) begin
               cmd_pop = 1'b1;
               ovalid_in = 1'b1; okind_in = KIND_CLOSE; ohit_in = 1'b0;
               oslot_in = '0; ofile_in = '0; opage_in = '0; olast_in = 1'b1;
            end
         end
         default: ;
      endcase
      hit_in = ohit_in;
   end

   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         rank_in[i] = rank_ff[i];
         if (do_touch) begin
            if (SLOT_BITS'(i) == touch_slot) rank_in[i] = '0;
            else if (rank_ff[i] < rank_ff[touch_slot]) rank_in[i] = rank_ff[i] + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         valid_ff  <= '0;
         dirty_ff  <= '0;
         ovalid_ff <= 1'b0;
         rptr_ff   <= '0;
         for (int i = 0; i < NUM_SLOTS; i++) rank_ff[i] <= SLOT_BITS'(i);
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         dirty_ff  <= dirty_in;
         ovalid_ff <= ovalid_in;
         rptr_ff   <= rptr_in;
         for (int i = 0; i < NUM_SLOTS; i++) rank_ff[i] <= rank_in[i];
      end
      tgt_ff <= tgt_in; hit_ff <= hit_in;
      okind_ff <= okind_in; ohit_ff <= ohit_in; oslot_ff <= oslot_in;
      ofile_ff <= ofile_in; opage_ff <= opage_in; olast_ff <= olast_in;
      if (do_fill) begin
         ftag_ff[touch_slot] <= cmd.file_id;
         ptag_ff[touch_slot] <= cmd.page_number;
      end
   end

   assign rsp_valid       = ovalid_ff;
   assign rsp_result_kind = okind_ff;
   assign rsp_was_hit     = ohit_ff && hit_ff;
   assign rsp_slot_index  = oslot_ff;
   assign rsp_victim_file = ofile_ff;
   assign rsp_victim_page = opage_ff;
   assign rsp_last_result = olast_ff;

`ifndef SYNTHESIS
   a_dirty_valid: assert property (@(posedge clock) disable iff (reset)
      (dirty_ff & ~valid_ff) == '0) else $error("dirty bit on empty slot");
   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      (ovalid_ff && !rsp_ready) |=> ovalid_ff && $stable(okind_ff))
      else $error("pending result changed");
   a_one_hit: assert property (@(posedge clock) disable iff (reset)
      cmd_valid |-> $onehot0(hit_vec)) else $error("duplicate tag");
   a_wb_then_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MISS_WB && out_free) |=> ovalid_ff && olast_ff)
      else $error("fill result missing after write-back");
`endif
endmodule

>>> rtl/core/lru_write_back_page_buffer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_write_back_page_buffer_top: page buffer pool tag controller
// Fully associative LRU slot pool with dirty tracking and close-file flush.
// ----------------------------------------------------------------------------
// A front stage takes requests into a two-entry queue (unused op codes are
// dropped there); a back stage executes one command at a time against four
// slots with a combinational parallel tag compare. A hit or a clean miss
// yields one item; a dirty-victim miss yields a write-back item, then an
// access item; a close starts the walk, walks all ranks, one per cycle
// while the output register is free, then emits close-done.
// Results leave through an output register and stall with rsp ready.
// ----------------------------------------------------------------------------
module lru_write_back_page_buffer_top import lwbpb_pkg::*; (
   input logic         clock,
   input logic         reset,
   lwbpb_req_if.sink   req,
   lwbpb_rsp_if.source rsp
);
   logic    cmd_valid, cmd_pop;
   cmd_type cmd;

   // Intake: classify and queue.
   lwbpb_front u_front (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready), .req_op(req.op),
      .req_file_id(req.file_id), .req_page_number(req.page_number),
      .cmd_valid, .cmd_pop, .cmd
   );

   // Execute: lookup, replace, flush.
   lwbpb_back u_back (
      .clock, .reset, .cmd_valid, .cmd_pop, .cmd,
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .rsp_result_kind(rsp.result_kind), .rsp_was_hit(rsp.was_hit),
      .rsp_slot_index(rsp.slot_index), .rsp_victim_file(rsp.victim_file),
      .rsp_victim_page(rsp.victim_page), .rsp_last_result(rsp.last_result)
   );
endmodule

>>> tb/sv/lru_write_back_page_buffer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_write_back_page_buffer_top_tb: self-checking bench for the page buffer
// Drives read, write, close and unused requests through the request channel,
// predicts the tag, dirty and recency behavior of the slot pool, and compares
// every result item field by field under several idle and stall patterns.
// ----------------------------------------------------------------------------
module lru_write_back_page_buffer_top_tb;
   import lwbpb_pkg::*;

   typedef struct packed {
      logic [1:0]                  op;
      logic [FILE_ID_BITS-1:0]     file_id;
      logic [PAGE_NUMBER_BITS-1:0] page_number;
   } page_req_t;

   typedef struct packed {
      logic [1:0]                  kind;
      logic                        hit;
      logic [SLOT_BITS-1:0]        slot;
      logic [FILE_ID_BITS-1:0]     vfile;
      logic [PAGE_NUMBER_BITS-1:0] vpage;
      logic                        last;
   } page_rsp_t;

   localparam int IDLE_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   lwbpb_req_if req_if ();
   lwbpb_rsp_if rsp_if ();

   lru_write_back_page_buffer_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source)
   );

   // Predicted pool state, indexed by slot.
   logic                        pool_valid [NUM_SLOTS];
   logic                        pool_dirty [NUM_SLOTS];
   logic [FILE_ID_BITS-1:0]     pool_file  [NUM_SLOTS];
   logic [PAGE_NUMBER_BITS-1:0] pool_page  [NUM_SLOTS];
   int                          pool_rank  [NUM_SLOTS];

   page_req_t pending_reqs [$];
   page_rsp_t expected_rsps [$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit recv_hold = 1'b0;
   int hold_cycles = 0;
   int error_count = 0;
   int rsp_count = 0;
   int req_count = 0;
   int wb_count = 0;
   int close_count = 0;
   int idle_cycles = 0;

   function automatic page_rsp_t make_rsp(logic [1:0] kind, logic hit, int slot,
                                          logic [FILE_ID_BITS-1:0] vf,
                                          logic [PAGE_NUMBER_BITS-1:0] vp,
                                          logic last);
      page_rsp_t r;
      r.kind = kind;
      r.hit = hit;
      r.slot = slot[SLOT_BITS-1:0];
      r.vfile = vf;
      r.vpage = vp;
      r.last = last;
      return r;
   endfunction

   function automatic int slot_at_rank(int r);
      for (int i = 0; i < NUM_SLOTS; i++)
         if (pool_rank[i] == r) return i;
      return 0;
   endfunction

   function automatic void promote_slot(int s);
      int prior;
      prior = pool_rank[s];
      for (int i = 0; i < NUM_SLOTS; i++)
         if (pool_rank[i] < prior) pool_rank[i]++;
      pool_rank[s] = 0;
   endfunction

   // Work out the result items of one accepted request and advance the pool.
   function automatic void predict_page_access(page_req_t q);
      int s;
      int target;
      target = -1;
      if (q.op == OP_NONE) return;
      if (q.op == OP_CLOSE) begin
         for (int r = 0; r < NUM_SLOTS; r++) begin
            s = slot_at_rank(r);
            if (pool_valid[s] && pool_file[s] == q.file_id) begin
               if (pool_dirty[s])
                  expected_rsps.push_back(make_rsp(KIND_WRITEBACK, 1'b0, s,
                                          pool_file[s], pool_page[s], 1'b0));
               pool_valid[s] = 1'b0;
               pool_dirty[s] = 1'b0;
            end
         end
         expected_rsps.push_back(make_rsp(KIND_CLOSE, 1'b0, 0, '0, '0, 1'b1));
         return;
      end
      for (int r = 0; r < NUM_SLOTS; r++) begin
         s = slot_at_rank(r);
         if (pool_valid[s] && pool_file[s] == q.file_id
             && pool_page[s] == q.page_number) begin
            if (q.op == OP_WRITE) pool_dirty[s] = 1'b1;
            promote_slot(s);
            expected_rsps.push_back(make_rsp(KIND_ACCESS, 1'b1, s, '0, '0, 1'b1));
            return;
         end
      end
      for (int r = 0; r < NUM_SLOTS && target < 0; r++) begin
         s = slot_at_rank(r);
         if (!pool_valid[s]) target = s;
      end
      if (target < 0) begin
         target = slot_at_rank(NUM_SLOTS - 1);
         if (pool_dirty[target])
            expected_rsps.push_back(make_rsp(KIND_WRITEBACK, 1'b0, target,
                                    pool_file[target], pool_page[target], 1'b0));
      end
      pool_valid[target] = 1'b1;
      pool_dirty[target] = (q.op == OP_WRITE);
      pool_file[target] = q.file_id;
      pool_page[target] = q.page_number;
      promote_slot(target);
      expected_rsps.push_back(make_rsp(KIND_ACCESS, 1'b0, target, '0, '0, 1'b1));
   endfunction

   // Driver: offer the head of the pending queue, advance on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predict_page_access(page_req_t'{req_if.op, req_if.file_id,
                                            req_if.page_number});
            req_count++;
            void'(pending_reqs.pop_front());
         end
         // Decide once per cycle whether the next item is offered.
         if (pending_reqs.size() > (req_if.valid && req_if.ready ? 0 : 0)
             && (req_if.valid && !req_if.ready
                 || $urandom_range(99) >= send_idle_pct)) begin
            req_if.valid <= 1'b1;
            req_if.op <= pending_reqs[0].op;
            req_if.file_id <= pending_reqs[0].file_id;
            req_if.page_number <= pending_reqs[0].page_number;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Monitor: check each accepted result against the oldest expectation.
   always @(posedge clock) begin
      page_rsp_t got;
      page_rsp_t want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = make_rsp(rsp_if.result_kind, rsp_if.was_hit, rsp_if.slot_index,
                        rsp_if.victim_file, rsp_if.victim_page, rsp_if.last_result);
         rsp_count++;
         if (got.kind == KIND_WRITEBACK) wb_count++;
         if (got.kind == KIND_CLOSE) close_count++;
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result item, expected none, actual %p",
                     $time, got);
            error_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (got.kind !== want.kind)
               $display("%0t: result_kind expected %0d actual %0d", $time,
                        want.kind, got.kind);
            if (got.hit !== want.hit)
               $display("%0t: was_hit expected %0d actual %0d", $time,
                        want.hit, got.hit);
            if (got.slot !== want.slot)
               $display("%0t: slot_index expected %0d actual %0d", $time,
                        want.slot, got.slot);
            if (got.vfile !== want.vfile)
               $display("%0t: victim_file expected %0h actual %0h", $time,
                        want.vfile, got.vfile);
            if (got.vpage !== want.vpage)
               $display("%0t: victim_page expected %0h actual %0h", $time,
                        want.vpage, got.vpage);
            if (got.last !== want.last)
               $display("%0t: last_result expected %0d actual %0d", $time,
                        want.last, got.last);
            if (got !== want) error_count++;
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off counted here.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (recv_hold) begin
         rsp_if.ready <= 1'b0;
         hold_cycles++;
         if (hold_cycles >= 60) begin
            recv_hold <= 1'b0;
            hold_cycles = 0;
         end
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: count cycles in which no item moves on either side.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles = 0;
      else if (!reset)
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: watchdog expired, %0d results outstanding", $time,
                  expected_rsps.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Hot set: small file and page ranges so hits, evictions and closes meet.
   function automatic page_req_t hot_req();
      page_req_t q;
      int pick;
      pick = $urandom_range(99);
      q.op = (pick < 40) ? OP_READ : (pick < 80) ? OP_WRITE :
             (pick < 94) ? OP_CLOSE : OP_NONE;
      q.file_id = (pick % 7 == 0) ? 8'($urandom) : 8'($urandom_range(3));
      q.page_number = ($urandom_range(9) == 0) ? 24'($urandom)
                                               : 24'($urandom_range(5));
      return q;
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_if.valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic run_phase(int idle_pct, int stall_pct, int count);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) pending_reqs.push_back(hot_req());
      wait_drained();
   endtask

   initial begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         pool_valid[i] = 1'b0;
         pool_dirty[i] = 1'b0;
         pool_file[i] = '0;
         pool_page[i] = '0;
         pool_rank[i] = i;
      end
      req_if.valid = 1'b0;
      req_if.op = OP_READ;
      req_if.file_id = '0;
      req_if.page_number = '0;
      rsp_if.ready = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, hits, dirty and clean evictions, closes, unused op.
      pending_reqs.push_back('{OP_WRITE, 8'hFF, 24'hFFFFFF});
      pending_reqs.push_back('{OP_READ,  8'h00, 24'h000000});
      pending_reqs.push_back('{OP_WRITE, 8'h01, 24'h000010});
      pending_reqs.push_back('{OP_READ,  8'h01, 24'h000011});
      pending_reqs.push_back('{OP_READ,  8'hFF, 24'hFFFFFF});
      pending_reqs.push_back('{OP_READ,  8'h00, 24'h000000});
      pending_reqs.push_back('{OP_WRITE, 8'h02, 24'hAAAAAA});
      pending_reqs.push_back('{OP_READ,  8'h02, 24'h555555});
      pending_reqs.push_back('{OP_NONE,  8'hFF, 24'hFFFFFF});
      pending_reqs.push_back('{OP_WRITE, 8'h00, 24'h000000});
      pending_reqs.push_back('{OP_CLOSE, 8'h00, 24'h123456});
      pending_reqs.push_back('{OP_CLOSE, 8'h77, 24'h000000});
      pending_reqs.push_back('{OP_WRITE, 8'h05, 24'h000001});
      pending_reqs.push_back('{OP_WRITE, 8'h05, 24'h000002});
      pending_reqs.push_back('{OP_WRITE, 8'h05, 24'h000003});
      pending_reqs.push_back('{OP_WRITE, 8'h05, 24'h000004});
      pending_reqs.push_back('{OP_CLOSE, 8'h05, 24'hFFFFFF});
      pending_reqs.push_back('{OP_READ,  8'h80, 24'h800000});
      pending_reqs.push_back('{OP_CLOSE, 8'h80, 24'h000000});
      wait_drained();

      // Sweep the idle patterns; each waits for every result before moving on.
      run_phase(0, 0, 60);
      run_phase(76, 0, 55);
      run_phase(0, 76, 55);
      run_phase(31, 31, 55);

      // Hold the receiver off while the sender keeps offering items.
      send_idle_pct = 0;
      recv_stall_pct = 0;
      @(posedge clock);
      recv_hold <= 1'b1;
      for (int i = 0; i < 40; i++) pending_reqs.push_back(hot_req());
      wait_drained();

      $display("Covered %0d requests, %0d result items (%0d write-backs, %0d closes)",
               req_count, rsp_count, wb_count, close_count);
      $display("under free-running, sender-idle, receiver-stall and long hold-off phases.");
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
